// ===== sv/ovl_pkg.sv =====
`default_nettype none

package ovl_pkg;

   // request operation codes
   typedef enum logic [1:0] {
      OP_APPEND = 2'd0,
      OP_SEARCH = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } ovl_op_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_RESP
   } ovl_state_type;

   // request item
   typedef struct packed {
      logic [1:0]         opcode;
      logic signed [31:0] value;
   } ovl_req_type;

   // result item
   typedef struct packed {
      logic       ok;
      logic [3:0] position;
      logic [4:0] length;
   } ovl_rsp_type;

endpackage

`default_nettype wire

// ===== sv/ovl_ram.sv =====
`default_nettype none

module ovl_ram #(
   parameter int WIDTH      = 32,
   parameter int DEPTH      = 16,
   parameter int ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]      wr_data,
   input  wire logic [ADDR_WIDTH-1:0] rd_addr,
   output logic      [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/ovl_ctrl.sv =====
`default_nettype none

module ovl_ctrl import ovl_pkg::*; #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32,
   parameter int IDX_WIDTH   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   parameter int CNT_WIDTH   = $clog2(CAPACITY + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire ovl_req_type            req_data,
   output logic                        req_stall,
   output logic                        ram_wr_en,
   output logic      [IDX_WIDTH-1:0]   ram_wr_addr,
   output logic      [VALUE_WIDTH-1:0] ram_wr_data,
   output logic      [IDX_WIDTH-1:0]   ram_rd_addr,
   input  wire logic [VALUE_WIDTH-1:0] ram_rd_data,
   input  wire logic                   out_free,
   output logic                        done,
   output ovl_rsp_type                 result
);

   localparam int EW = CNT_WIDTH + 1;

   ovl_state_type          state_ff, state_in;
   ovl_op_type             op_ff, op_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [IDX_WIDTH-1:0]   idx_ff, idx_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   ok_ff, ok_in;
   logic [IDX_WIDTH-1:0]   pos_ff, pos_in;

   logic [EW-1:0]          idx_w, idx_p1, idx_p2, count_w;
   logic signed [63:0]     value_ext;
   logic [VALUE_WIDTH-1:0] req_key;
   logic [63:0]            pos_ext, count_ext;
   logic                   full, hit;

   // widened index arithmetic against the fill count
   assign idx_w     = EW'(idx_ff);
   assign idx_p1    = idx_w + EW'(1);
   assign idx_p2    = idx_w + EW'(2);
   assign count_w   = EW'(count_ff);
   assign full      = (count_w == EW'(CAPACITY));
   assign hit       = (ram_rd_data == key_ff);

   // stored key is the sign-extended value cut to the entry width
   assign value_ext = 64'(req_data.value);
   assign req_key   = value_ext[VALUE_WIDTH-1:0];

   // result fields cut to their port widths
   assign pos_ext   = 64'(pos_ff);
   assign count_ext = 64'(count_ff);
   assign result.ok       = ok_ff;
   assign result.position = pos_ext[3:0];
   assign result.length   = count_ext[4:0];

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // per-item working registers
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      key_ff <= key_in;
      idx_ff <= idx_in;
      ok_ff  <= ok_in;
      pos_ff <= pos_in;
   end

   // sequencer: scan one entry per cycle, shift one entry per cycle
   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      idx_in      = idx_ff;
      count_in    = count_ff;
      ok_in       = ok_ff;
      pos_in      = pos_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_addr = idx_p1[IDX_WIDTH-1:0];
      req_stall   = (state_ff != ST_IDLE);
      done        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            ram_rd_addr = '0;
            if (req_valid) begin
               op_in  = ovl_op_type'(req_data.opcode);
               key_in = req_key;
               idx_in = '0;
               ok_in  = 1'b0;
               pos_in = '0;
               unique case (ovl_op_type'(req_data.opcode))
                  OP_APPEND: begin
                     if (!full) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_w[IDX_WIDTH-1:0];
                        ram_wr_data = req_key;
                        count_in    = count_ff + CNT_WIDTH'(1);
                        ok_in       = 1'b1;
                     end
                     state_in = ST_RESP;
                  end
                  OP_SEARCH, OP_REMOVE: begin
                     state_in = (count_ff == '0) ? ST_RESP : ST_SCAN;
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     ok_in    = 1'b1;
                     state_in = ST_RESP;
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end

         ST_SCAN: begin
            if (hit) begin
               ok_in  = 1'b1;
               pos_in = idx_ff;
               if (op_ff == OP_REMOVE) begin
                  if (idx_p1 < count_w) begin
                     state_in = ST_SHIFT;
                  end else begin
                     count_in = count_ff - CNT_WIDTH'(1);
                     state_in = ST_RESP;
                  end
               end else begin
                  state_in = ST_RESP;
               end
            end else if (idx_p1 < count_w) begin
               idx_in = idx_p1[IDX_WIDTH-1:0];
            end else begin
               state_in = ST_RESP;
            end
         end

         // read data holds the entry above idx; move it down one place
         ST_SHIFT: begin
            ram_wr_en   = 1'b1;
            ram_rd_addr = idx_p2[IDX_WIDTH-1:0];
            idx_in      = idx_p1[IDX_WIDTH-1:0];
            if (idx_p2 >= count_w) begin
               count_in = count_ff - CNT_WIDTH'(1);
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            done = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/ordered_value_list.sv =====
// Append and clear: the result is registered, via the response state, after the item is accepted.
// Search: scans from entry 0 up to the first match or the end; one entry memory read per cycle.
// Remove: scans like search, then on a hit later entries move down one per cycle.
// No item is taken until the last result is registered; the next is taken from the idle state after it.
// A stalled output register holds the sequencer, and with it the input, until it is taken.
// Reset (synchronous) empties the list and the output register; the entry memory is not cleared.
`default_nettype none

module ordered_value_list import ovl_pkg::*; #(
   parameter int CAPACITY    = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire ovl_req_type req_data,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output ovl_rsp_type      rsp_data
);

   localparam int IDX_WIDTH = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_WIDTH = $clog2(CAPACITY + 1);

   logic                   ram_wr_en;
   logic [IDX_WIDTH-1:0]   ram_wr_addr;
   logic [VALUE_WIDTH-1:0] ram_wr_data;
   logic [IDX_WIDTH-1:0]   ram_rd_addr;
   logic [VALUE_WIDTH-1:0] ram_rd_data;
   logic                   out_free;
   logic                   done;
   ovl_rsp_type            result;

   logic                   rsp_valid_ff, rsp_valid_in;
   ovl_rsp_type            rsp_data_ff;

   // entry storage
   ovl_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // request sequencer and fill count
   ovl_ctrl #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH),
      .IDX_WIDTH   (IDX_WIDTH),
      .CNT_WIDTH   (CNT_WIDTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_data    (req_data),
      .req_stall   (req_stall),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .out_free    (out_free),
      .done        (done),
      .result      (result)
   );

   // output register: free when empty or being taken this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result item payload
   always_ff @(posedge clock) begin
      if (done) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import ovl_pkg::*;

   localparam int CAPACITY      = 16;
   localparam int VALUE_WIDTH   = 32;
   localparam int RANDOM_ITEMS  = 1325;
   localparam int HOLD_AFTER    = 400;
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 48;
   localparam int CYCLE_LIMIT   = 800000;

   localparam logic [31:0] CORNER_VALUES [5] = '{
      32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff, 32'h0000_0001
   };

   // shadow of the list plus the queue of results still owed by the block
   class list_scoreboard;
      typedef struct {
         ovl_req_type req;
         ovl_rsp_type want;
      } awaited_type;

      logic [VALUE_WIDTH-1:0] entries [CAPACITY];
      int                     fill;
      awaited_type            awaited [$];
      int                     checked, mismatches;
      int                     appended, full_rejects, found, not_found;
      int                     removed, missed, cleared, deepest;

      function void flag(string text);
         mismatches++;
         if (mismatches <= 10) $display("[%0t] MISMATCH %s", $time, text);
      endfunction

      // apply an accepted item to the shadow list and queue its result
      function void note_request(ovl_req_type item);
         awaited_type rec;
         int          hit;
         hit = -1;
         rec.req = item;
         rec.want = '0;
         for (int i = 0; i < fill; i++)
            if (hit < 0 && entries[i] == item.value[VALUE_WIDTH-1:0]) hit = i;
         case (item.opcode)
            OP_APPEND: begin
               if (fill < CAPACITY) begin
                  entries[fill] = item.value[VALUE_WIDTH-1:0];
                  fill++;
                  rec.want.ok = 1'b1;
                  appended++;
               end else begin
                  full_rejects++;
               end
            end
            OP_SEARCH: begin
               if (hit >= 0) begin
                  rec.want.ok = 1'b1;
                  rec.want.position = 4'(hit);
                  found++;
               end else begin
                  not_found++;
               end
            end
            OP_REMOVE: begin
               if (hit >= 0) begin
                  rec.want.ok = 1'b1;
                  rec.want.position = 4'(hit);
                  // close the gap left by the removed entry
                  for (int i = hit; i + 1 < fill; i++) entries[i] = entries[i + 1];
                  fill--;
                  removed++;
               end else begin
                  missed++;
               end
            end
            default: begin
               fill = 0;
               rec.want.ok = 1'b1;
               cleared++;
            end
         endcase
         rec.want.length = 5'(fill);
         if (fill > deepest) deepest = fill;
         awaited.push_back(rec);
      endfunction

      // compare one accepted result with the oldest one owed
      function void check_result(ovl_rsp_type got);
         awaited_type head;
         ovl_op_type  op;
         string       bad;
         checked++;
         if (awaited.size() == 0) begin
            flag($sformatf("result with nothing owed: ok=%0d pos=%0d len=%0d",
                           got.ok, got.position, got.length));
            return;
         end
         head = awaited.pop_front();
         op = ovl_op_type'(head.req.opcode);
         bad = "";
         if (got.ok !== head.want.ok) bad = {bad, " ok"};
         if (got.position !== head.want.position) bad = {bad, " position"};
         if (got.length !== head.want.length) bad = {bad, " length"};
         if (bad != "")
            flag($sformatf({"%s %h, field(s)%s: expected ok=%0d pos=%0d len=%0d,",
                            " got ok=%0d pos=%0d len=%0d"},
                           op.name(), head.req.value, bad,
                           head.want.ok, head.want.position, head.want.length,
                           got.ok, got.position, got.length));
      endfunction
   endclass

   logic        clock;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   ovl_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   ovl_rsp_type rsp_data;

   list_scoreboard ledger = new();
   int             cycle_count = 0;

   ordered_value_list #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 50 MHz clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[%0t] timeout with %0d results still owed", $time, ledger.awaited.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // idle length: mode 0 never idles, 1 is light, 2 is heavy
   function automatic int pick_gap(int mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (mode == 0) return 0;
      if (mode == 1) begin
         if (roll < 75) return 0;
         if (roll < 96) return $urandom_range(1, 3);
         return $urandom_range(8, 30);
      end
      if (roll < 40) return 0;
      if (roll < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   // offer one item after an optional idle gap and wait for it to be taken
   task automatic send_request(ovl_req_type item, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      ledger.note_request(item);
   endtask

   task automatic offer(ovl_op_type op, logic [31:0] value, int gap_mode);
      ovl_req_type item;
      item.opcode = op;
      item.value  = value;
      send_request(item, pick_gap(gap_mode));
   endtask

   // corners: empty list, extremes, duplicates, full list, removal of a duplicate and of the last entry
   task automatic run_directed();
      offer(OP_CLEAR, 32'h0000_0000, 1);
      offer(OP_SEARCH, 32'h0000_0000, 1);
      offer(OP_REMOVE, 32'h7fff_ffff, 1);
      foreach (CORNER_VALUES[k]) offer(OP_APPEND, CORNER_VALUES[k], 1);
      offer(OP_APPEND, 32'h7fff_ffff, 1);
      offer(OP_APPEND, 32'h5555_5555, 1);
      offer(OP_APPEND, 32'haaaa_aaaa, 1);
      for (int i = 0; i < 7; i++) offer(OP_APPEND, $urandom(), 1);
      offer(OP_APPEND, 32'h1357_9bdf, 1);
      offer(OP_APPEND, 32'hdead_beef, 1);
      offer(OP_SEARCH, 32'h7fff_ffff, 1);
      offer(OP_SEARCH, 32'h7fff_fffe, 1);
      offer(OP_REMOVE, 32'h7fff_ffff, 1);
      offer(OP_REMOVE, 32'h1357_9bdf, 1);
      offer(OP_CLEAR, $urandom(), 1);
   endtask

   // phases of fill, drain and mixed traffic over a small value pool, some noise
   task automatic run_random(int total);
      logic [31:0] pool [5];
      logic [31:0] base;
      logic [31:0] value;
      ovl_op_type  op;
      int          done, kind, span, gap_mode, roll;
      int          append_cut, search_cut, remove_cut;
      done = 0;
      while (done < total) begin
         kind     = $urandom_range(0, 9);
         span     = (kind == 9) ? $urandom_range(5, 15) : $urandom_range(20, 60);
         gap_mode = $urandom_range(0, 2);
         base     = $urandom();
         if (kind < 3) begin
            append_cut = 70; search_cut = 85; remove_cut = 97;
         end else if (kind < 6) begin
            append_cut = 22; search_cut = 47; remove_cut = 98;
         end else begin
            append_cut = 40; search_cut = 70; remove_cut = 98;
         end
         // pool mixes random words, single-bit neighbors and extremes
         foreach (pool[k]) begin
            case ($urandom_range(0, 2))
               0:       pool[k] = $urandom();
               1:       pool[k] = base ^ (32'h1 << $urandom_range(0, 31));
               default: pool[k] = CORNER_VALUES[$urandom_range(0, 4)];
            endcase
         end
         for (int n = 0; n < span && done < total; n++) begin
            roll = $urandom_range(0, 99);
            if (kind == 9) begin
               op    = ovl_op_type'($urandom_range(0, 3));
               value = $urandom();
            end else begin
               op = (roll < append_cut) ? OP_APPEND :
                    (roll < search_cut) ? OP_SEARCH :
                    (roll < remove_cut) ? OP_REMOVE : OP_CLEAR;
               value = ($urandom_range(0, 6) == 0) ? $urandom() : pool[$urandom_range(0, 4)];
            end
            offer(op, value, gap_mode);
            done++;
         end
      end
   endtask

   // result side stalls, with one long hold-off so the block backs up
   initial begin : receiver
      int  left, mode, mode_left;
      bit  held;
      left = 0;
      mode = 0;
      mode_left = 0;
      held = 1'b0;
      wait (reset == 1'b0);
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode = $urandom_range(0, 2);
            mode_left = $urandom_range(100, 300);
         end
         mode_left--;
         if (left > 0) begin
            left--;
         end else if (!held && ledger.checked >= HOLD_AFTER) begin
            held = 1'b1;
            left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            left = pick_gap(mode);
            rsp_stall <= (left != 0);
            if (left > 0) left--;
         end
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) ledger.check_result(rsp_data);
   end

   // reset, stimulus and end of run
   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random(RANDOM_ITEMS);
      req_valid <= 1'b0;
      while (ledger.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d items: %0d appended, %0d refused on a full list, %0d clears,",
               ledger.checked, ledger.appended, ledger.full_rejects, ledger.cleared);
      $display("deepest %0d, searches %0d found / %0d missed, removes %0d done / %0d missed",
               ledger.deepest, ledger.found, ledger.not_found, ledger.removed,
               ledger.missed);
      if (ledger.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
